/* src/tkis_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tkis_pkg;

  localparam int CAPACITY = 64;
  localparam int SCORE_W  = 32;
  localparam int TAG_W    = 16;
  localparam int RANK_W   = 6;
  localparam int KEEP_W   = 7;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam logic CFG_KEEP_COUNT = 1'b0;
  localparam logic CFG_DESCENDING = 1'b1;

  typedef struct packed {
    logic                      valid;
    logic signed [SCORE_W-1:0] score;
    logic [TAG_W-1:0]          tag;
  } entry_t;

  // Control broadcast from the sequencer to every cell of the chain.
  typedef struct packed {
    logic                      insert;
    logic                      shift_left;
    logic                      clear;
    logic                      dir;
    logic signed [SCORE_W-1:0] score;
    logic [TAG_W-1:0]          tag;
  } ctrl_t;

  // True when score a belongs strictly ahead of score b.
  function automatic logic ahead(input logic signed [SCORE_W-1:0] a,
                                 input logic signed [SCORE_W-1:0] b,
                                 input logic dir);
    ahead = dir ? (a > b) : (a < b);
  endfunction

endpackage

`default_nettype wire

/* src/tkis_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module tkis_cell (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire tkis_pkg::ctrl_t  ctrl,
  input  wire tkis_pkg::entry_t prev_entry,
  input  wire logic           prev_ins,
  input  wire tkis_pkg::entry_t next_entry,
  output tkis_pkg::entry_t      entry,
  output logic                ins
);
  import tkis_pkg::*;

  entry_t entry_r;
  entry_t entry_nxt;

  // The store is sorted, so ins is false over a prefix and true after it.
  assign ins   = !entry_r.valid || ahead(ctrl.score, entry_r.score, ctrl.dir);
  assign entry = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.clear) begin
      entry_nxt.valid = 1'b0;
    end else if (ctrl.shift_left) begin
      entry_nxt = next_entry;
    end else if (ctrl.insert && ins) begin
      if (prev_ins) begin
        entry_nxt = prev_entry;
      end else begin
        entry_nxt.valid = 1'b1;
        entry_nxt.score = ctrl.score;
        entry_nxt.tag   = ctrl.tag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r.valid <= 1'b0;
    end else begin
      entry_r.valid <= entry_nxt.valid;
    end
    entry_r.score <= entry_nxt.score;
    entry_r.tag   <= entry_nxt.tag;
  end

endmodule

`default_nettype wire

/* src/top_k_index_sorter.sv */
// Accepts one scored request per cycle while a set is being collected.
// The first result is registered once the request carrying set_end is
// accepted and the output is free; results leave one per cycle from the head
// of the chain while out_ready holds. No input request is accepted in a drain.
// Reset clears the chain, the fill count and the output, and restores
// keep_count to 64 and descending to 0.
`timescale 1ns / 1ps
`default_nettype none

module top_k_index_sorter (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic signed [tkis_pkg::SCORE_W-1:0]   in_score,
  input  wire logic [tkis_pkg::TAG_W-1:0]            in_tag,
  input  wire logic                                  in_set_end,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic signed [tkis_pkg::SCORE_W-1:0]        out_score,
  output logic [tkis_pkg::TAG_W-1:0]                 out_tag,
  output logic [tkis_pkg::RANK_W-1:0]                out_rank,
  output logic                                       out_final_result,
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic                                  cfg_index,
  input  wire logic [tkis_pkg::KEEP_W-1:0]           cfg_data
);
  import tkis_pkg::*;

  localparam logic STATE_RUN   = 1'b0;
  localparam logic STATE_DRAIN = 1'b1;

  logic              state_r, state_nxt;
  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic [CNT_W-1:0]  remain_r, remain_nxt;
  logic [RANK_W-1:0] rank_r, rank_nxt;
  logic              dir_r, dir_nxt;
  logic [KEEP_W-1:0] keep_count_r;
  logic              descending_r;

  logic                      out_valid_r, out_valid_nxt;
  logic signed [SCORE_W-1:0] out_score_r;
  logic [TAG_W-1:0]          out_tag_r;
  logic [RANK_W-1:0]         out_rank_r;
  logic                      out_final_r;

  ctrl_t  ctrl;
  entry_t cell_entry [CAPACITY];
  logic   cell_ins   [CAPACITY];

  logic              in_acc;
  logic              load;
  logic              cur_dir;
  logic [CNT_W-1:0]  fill_after;
  logic [CNT_W-1:0]  keep_eff;

  assign in_ready  = (state_r == STATE_RUN);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign load      = (state_r == STATE_DRAIN) && (!out_valid_r || out_ready);

  // The direction is taken from the register on the first request of a set.
  assign cur_dir    = (fill_r == '0) ? descending_r : dir_r;
  assign fill_after = (fill_r < CNT_W'(CAPACITY)) ? fill_r + CNT_W'(1) : fill_r;

  always_comb begin
    if (keep_count_r == '0) begin
      keep_eff = CNT_W'(1);
    end else if (keep_count_r > KEEP_W'(CAPACITY)) begin
      keep_eff = CNT_W'(CAPACITY);
    end else begin
      keep_eff = CNT_W'(keep_count_r);
    end
  end

  always_comb begin
    ctrl.insert     = in_acc;
    ctrl.shift_left = load && (remain_r != CNT_W'(1));
    ctrl.clear      = load && (remain_r == CNT_W'(1));
    ctrl.dir        = cur_dir;
    ctrl.score      = in_score;
    ctrl.tag        = in_tag;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t prev_e;
    entry_t next_e;
    logic   prev_i;
    if (i == 0) begin : g_head
      assign prev_e = '0;
      assign prev_i = 1'b0;
    end else begin : g_mid
      assign prev_e = cell_entry[i-1];
      assign prev_i = cell_ins[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign next_e = '0;
    end else begin : g_body
      assign next_e = cell_entry[i+1];
    end
    tkis_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .prev_entry (prev_e),
      .prev_ins   (prev_i),
      .next_entry (next_e),
      .entry      (cell_entry[i]),
      .ins        (cell_ins[i])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    remain_nxt    = remain_r;
    rank_nxt      = rank_r;
    dir_nxt       = dir_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    if (in_acc) begin
      fill_nxt = fill_after;
      dir_nxt  = cur_dir;
      if (in_set_end) begin
        state_nxt  = STATE_DRAIN;
        remain_nxt = (fill_after < keep_eff) ? fill_after : keep_eff;
        rank_nxt   = '0;
      end
    end
    if (load) begin
      out_valid_nxt = 1'b1;
      remain_nxt    = remain_r - CNT_W'(1);
      rank_nxt      = rank_r + RANK_W'(1);
      if (remain_r == CNT_W'(1)) begin
        state_nxt = STATE_RUN;
        fill_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= STATE_RUN;
      fill_r       <= '0;
      remain_r     <= '0;
      rank_r       <= '0;
      dir_r        <= 1'b0;
      out_valid_r  <= 1'b0;
      keep_count_r <= KEEP_W'(64);
      descending_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      remain_r    <= remain_nxt;
      rank_r      <= rank_nxt;
      dir_r       <= dir_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_KEEP_COUNT: keep_count_r <= cfg_data;
          CFG_DESCENDING: descending_r <= cfg_data[0];
          default:        keep_count_r <= keep_count_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_score_r <= cell_entry[0].score;
      out_tag_r   <= cell_entry[0].tag;
      out_rank_r  <= rank_r;
      out_final_r <= (remain_r == CNT_W'(1));
    end
  end

  assign out_valid        = out_valid_r;
  assign out_score        = out_score_r;
  assign out_tag          = out_tag_r;
  assign out_rank         = out_rank_r;
  assign out_final_result = out_final_r;

endmodule

`default_nettype wire

/* src/tkis_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module tkis_checker (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               in_valid,
  input wire logic                               in_ready,
  input wire logic                               in_set_end,
  input wire logic                               out_valid,
  input wire logic                               out_ready,
  input wire logic signed [tkis_pkg::SCORE_W-1:0] out_score,
  input wire logic [tkis_pkg::TAG_W-1:0]          out_tag,
  input wire logic [tkis_pkg::RANK_W-1:0]         out_rank,
  input wire logic                               out_final_result
);
  import tkis_pkg::*;

  // A stalled result must hold.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_score) && $stable(out_tag)
      && $stable(out_rank) && $stable(out_final_result))
    else $error("stalled result changed");

  // Closing a set stops input until its results are drained.
  a_set_end_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_set_end |=> !in_ready)
    else $error("input open right after end of set");

  // A non-final result is only ever seen while the drain holds off input.
  a_drain_closed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_final_result |-> !in_ready)
    else $error("input open during drain");

  // Ranks climb by one within a set.
  a_rank_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_final_result ##1 out_valid
      |-> out_rank == $past(out_rank) + RANK_W'(1))
    else $error("rank sequence broken");

  // Nothing comes out right after reset.
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind top_k_index_sorter tkis_checker u_tkis_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .in_set_end       (in_set_end),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_score        (out_score),
  .out_tag          (out_tag),
  .out_rank         (out_rank),
  .out_final_result (out_final_result)
);

`default_nettype wire
